// File: design/pbfc_pkg.sv
// Shared constants, types and the base decoder of the position frequency counter.
`timescale 1ns / 1ps

package pbfc_pkg;

    // Table geometry and counter width.
    localparam int POSITIONS   = 15;
    localparam int TABLES      = 4;
    localparam int COUNT_WIDTH = 32;
    localparam int BASES       = 4;
    localparam int CODE_W      = 2;
    localparam int ROWS        = TABLES * POSITIONS;
    localparam int ROW_IDX_W   = $clog2(ROWS);
    localparam int ROW_DATA_W  = BASES * COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Result widths and the divider datapath.
    localparam int OUT_W     = 32;
    localparam int PM_W      = 10;
    localparam int PM_SCALE  = 1000;
    localparam int SUM_W     = COUNT_WIDTH + 2;
    localparam int PROD_W    = COUNT_WIDTH + PM_W;
    localparam int DIV_W     = SUM_W + PM_W - 1;
    localparam int DIV_CNT_W = $clog2(PM_W);

    // Command queue depth.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Action codes.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Base codes, one per counter within a row.
    localparam logic [CODE_W-1:0] BASE_A = 2'd0;
    localparam logic [CODE_W-1:0] BASE_C = 2'd1;
    localparam logic [CODE_W-1:0] BASE_G = 2'd2;
    localparam logic [CODE_W-1:0] BASE_T = 2'd3;

    // Raw nucleotide characters.
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_T_UP = 8'h54;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } base_dec_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic                 is_query;
        logic                 in_range;
        logic                 base_ok;
        logic [CODE_W-1:0]    code;
        logic [ROW_IDX_W-1:0] row;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // Map a raw character to a base code; anything else is not a base.
    function automatic base_dec_t base_decode(input logic [7:0] ch);
        base_dec_t d;
        d.ok   = 1'b1;
        d.code = BASE_A;
        unique case (ch) inside
            CH_A_LO, CH_A_UP: d.code = BASE_A;
            CH_C_LO, CH_C_UP: d.code = BASE_C;
            CH_G_LO, CH_G_UP: d.code = BASE_G;
            CH_T_LO, CH_T_UP: d.code = BASE_T;
            default:          d.ok   = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// File: design/position_base_frequency_counter_unit.sv
// Position-by-base frequency counter, top level.
// An accepted beat passes the front holding register and the queue before the back end
// pops it; an add writes its row in the read state, and a query presents its result beat
// after the read and sum states and the 10-step restoring divider (skipped when empty).
// The back end finishes one command before it pops the next; a stalled result holds it.
// Reset clears all counts at once through per-row valid bits; no clearing pass.
`timescale 1ns / 1ps

module position_base_frequency_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [1:0]  table_req,
    input  logic [3:0]  position,
    input  logic [7:0]  base,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] count,
    output logic [31:0] total,
    output logic [9:0]  permille,
    output logic        empty_res
);
    import pbfc_pkg::*;

    q_push_t push;
    q_head_t q_head;
    logic    full;
    logic    pop;

    // Accept and classify beats.
    pbfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .table_req (table_req),
        .position  (position),
        .base      (base),
        .full      (full),
        .push      (push)
    );

    // Decouple the front from the back.
    pbfc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .q_head (q_head),
        .pop    (pop)
    );

    // Execute commands against the count memory.
    pbfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .total     (total),
        .permille  (permille),
        .empty_res (empty_res)
    );

endmodule

// File: design/pbfc_front.sv
// Front end: accepts input beats, classifies them and hands them to the queue.
`timescale 1ns / 1ps

module pbfc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [1:0]        table_req,
    input  logic [3:0]        position,
    input  logic [7:0]        base,
    input  logic              full,
    output pbfc_pkg::q_push_t push
);
    import pbfc_pkg::*;

    logic      fr_valid_reg, fr_valid_next;
    cmd_t      fr_cmd_reg;
    cmd_t      cls;
    base_dec_t dec;
    logic      accept;

    // Classify the incoming beat: action, range check, base code and row.
    always_comb
    begin
        dec          = base_decode(base);
        cls.is_query = (action == ACT_QUERY);
        cls.in_range = (int'(table_req) < TABLES) && (int'(position) < POSITIONS);
        cls.base_ok  = dec.ok;
        cls.code     = dec.code;
        if (cls.in_range)
        begin
            cls.row = ROW_IDX_W'(int'(table_req) * POSITIONS + int'(position));
        end
        else
        begin
            cls.row = '0;
        end
    end

    // The holding register stalls only when it is full and the queue is too.
    assign in_stall      = fr_valid_reg && full;
    assign accept        = in_valid && !in_stall;
    assign fr_valid_next = accept || (fr_valid_reg && full);
    assign push.push     = fr_valid_reg;
    assign push.cmd      = fr_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_cmd_reg <= cls;
        end
    end

endmodule

// File: design/pbfc_queue.sv
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps

module pbfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  pbfc_pkg::q_push_t push,
    output logic              full,
    output pbfc_pkg::q_head_t q_head,
    input  logic              pop
);
    import pbfc_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full         = (fill_reg == QCNT_W'(QDEPTH));
    assign q_head.valid = (fill_reg != '0);
    assign q_head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push      = push.push && !full;
    assign do_pop       = pop && q_head.valid;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    // A command offered to a full queue stays offered and unchanged.
    a_push_held_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push && full) |=> push.push && $stable(push.cmd))
        else $error("command offered to a full queue was dropped or changed");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");

endmodule

// File: design/pbfc_back.sv
// Back end: count memory, read-modify-write for adds, sum and divide for queries.
`timescale 1ns / 1ps

module pbfc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbfc_pkg::q_head_t      q_head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [pbfc_pkg::OUT_W-1:0] count,
    output logic [pbfc_pkg::OUT_W-1:0] total,
    output logic [pbfc_pkg::PM_W-1:0]  permille,
    output logic                   empty_res
);
    import pbfc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]             state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;

    // Count memory: one row of four counters per table and position.
    logic [ROW_DATA_W-1:0]  mem [ROWS];
    logic [ROWS-1:0]        row_vld_reg;
    logic [ROW_DATA_W-1:0]  rd_row_reg;
    logic                   rd_vld_reg;
    logic [ROW_DATA_W-1:0]  cur_row, new_row;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic                   mem_we;

    // Query datapath.
    logic [COUNT_WIDTH:0]   s01_reg, s01_next, s23_reg, s23_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] tot_reg, tot_next;
    logic                   empty_reg, empty_next;
    logic [PROD_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [PM_W-1:0]        quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;
    logic                   div_ge;

    // Output register.
    logic                   load_out;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       count_reg, total_reg;
    logic [PM_W-1:0]        permille_reg;
    logic                   empty_res_reg;

    // Row as read; a row never written holds zeros.
    always_comb
    begin
        cur_row = rd_vld_reg ? rd_row_reg : '0;
        cur_cnt = cur_row[cmd_reg.code * COUNT_WIDTH +: COUNT_WIDTH];
        new_row = cur_row;
        if (cur_cnt != COUNT_MAX)
        begin
            new_row[cmd_reg.code * COUNT_WIDTH +: COUNT_WIDTH] = cur_cnt + 1'b1;
        end
    end

    assign mem_we = (state_reg == ST_READ) && !cmd_reg.is_query
                    && cmd_reg.in_range && cmd_reg.base_ok;
    assign sum    = SUM_W'(s01_reg) + SUM_W'(s23_reg);
    assign div_ge = (DIV_W'(rem_reg) >= div_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        s01_next   = s01_reg;
        s23_next   = s23_reg;
        cnt_next   = cnt_reg;
        tot_next   = tot_reg;
        empty_next = empty_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_head.cmd;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Adds write back here; queries collect the row.
                if (cmd_reg.is_query)
                begin
                    if (cmd_reg.in_range)
                    begin
                        s01_next = (COUNT_WIDTH + 1)'(cur_row[0 +: COUNT_WIDTH])
                                 + (COUNT_WIDTH + 1)'(cur_row[COUNT_WIDTH +: COUNT_WIDTH]);
                        s23_next = (COUNT_WIDTH + 1)'(cur_row[2 * COUNT_WIDTH +: COUNT_WIDTH])
                                 + (COUNT_WIDTH + 1)'(cur_row[3 * COUNT_WIDTH +: COUNT_WIDTH]);
                    end
                    else
                    begin
                        s01_next = '0;
                        s23_next = '0;
                    end
                    cnt_next   = (cmd_reg.in_range && cmd_reg.base_ok) ? cur_cnt : '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                tot_next   = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
                empty_next = !cmd_reg.base_ok || (sum == '0);
                rem_next   = PROD_W'(cnt_reg) * PROD_W'(PM_SCALE);
                div_next   = DIV_W'(sum) << (PM_W - 1);
                quo_next   = '0;
                step_next  = DIV_CNT_W'(PM_W - 1);
                state_next = empty_next ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                // One restoring quotient bit per cycle, most significant first.
                if (div_ge)
                begin
                    rem_next = rem_reg - div_reg[PROD_W-1:0];
                end
                quo_next  = {quo_reg[PM_W-2:0], div_ge};
                div_next  = div_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                load_out = !out_valid_reg || !out_stall;
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                row_vld_reg[cmd_reg.row] <= 1'b1;
            end
        end
    end

    // Memory: registered read at the queue head, write back of the updated row.
    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem[q_head.cmd.row];
        rd_vld_reg <= row_vld_reg[q_head.cmd.row];
        if (mem_we)
        begin
            mem[cmd_reg.row] <= new_row;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        s01_reg   <= s01_next;
        s23_reg   <= s23_next;
        cnt_reg   <= cnt_next;
        tot_reg   <= tot_next;
        empty_reg <= empty_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
        if (load_out)
        begin
            count_reg     <= OUT_W'(cnt_reg);
            total_reg     <= OUT_W'(tot_reg);
            permille_reg  <= quo_reg;
            empty_res_reg <= empty_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign total     = total_reg;
    assign permille  = permille_reg;
    assign empty_res = empty_res_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE) && q_head.valid)
        else $error("queue popped outside idle or while empty");

    a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> row_vld_reg[$past(cmd_reg.row)])
        else $error("written row not marked valid");

    a_permille_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (quo_reg <= PM_W'(PM_SCALE)))
        else $error("per-mille quotient above scale");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
